// File: hw/rtl/dnsfa_pkg.sv
// Package for the DNS first A record extractor.
// Holds the protocol constants and field lengths; depends on nothing.
package dnsfa_pkg;

    localparam logic [15:0] QR_BIT     = 16'h8000;
    localparam logic [15:0] RCODE_MASK = 16'h000F;
    localparam logic [15:0] TYPE_A     = 16'h0001;
    localparam logic [15:0] CLASS_IN   = 16'h0001;
    localparam logic [15:0] RDATA_A    = 16'h0004;
    localparam logic [7:0]  PTR_MARK   = 8'hC0;
    localparam logic [7:0]  MAX_LABEL  = 8'd63;

    localparam logic [3:0]  HDR_LEN    = 4'd12;
    localparam logic [3:0]  QFIX_LEN   = 4'd4;
    localparam logic [3:0]  AFIX_LEN   = 4'd10;
    localparam logic [3:0]  ADDR_LEN   = 4'd4;

    localparam logic [3:0]  HDR_ID_END = 4'd4;
    localparam logic [3:0]  HDR_QD_END = 4'd6;
    localparam logic [3:0]  HDR_AN_END = 4'd8;
    localparam logic [3:0]  AF_TYPE_END  = 4'd2;
    localparam logic [3:0]  AF_CLASS_END = 4'd4;
    localparam logic [3:0]  AF_TTL_END   = 4'd8;

endpackage

// File: hw/rtl/dns_first_a_record_extractor.sv
// DNS first A record extractor: byte serial response parser, result register.
// Depends on dnsfa_pkg.
// Throughput: one byte per cycle; state steps per byte until found or failed.
// Latency: the result is valid the cycle after the final byte is taken.
// A waiting result stalls input only when it is not taken that cycle.
// Reset (synchronous, active low) clears the parser, the result and expected id.
module dns_first_a_record_extractor
    import dnsfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_status,
    output logic [31:0] o_ip_address,
    output logic [31:0] o_record_ttl
);

    typedef enum logic [3:0] {
        PH_HDR, PH_NAME, PH_LABEL, PH_PTR, PH_QFIX, PH_AFIX, PH_SKIP, PH_ADDR, PH_IDLE
    } t_phase;

    logic [15:0] r_expected_id;
    t_phase      r_phase, n_phase;
    logic [3:0]  r_count, n_count;
    logic [31:0] r_shift, n_shift;
    logic [15:0] r_qleft, n_qleft;
    logic [15:0] r_aleft, n_aleft;
    logic [5:0]  r_lbl, n_lbl;
    logic [15:0] r_rtype, n_rtype;
    logic [15:0] r_rclass, n_rclass;
    logic [31:0] r_ttl, n_ttl;
    logic [15:0] r_rdata, n_rdata;
    logic        r_found, n_found;
    logic        r_failed, n_failed;

    logic        r_out_valid;
    logic        r_status;
    logic [31:0] r_ip;
    logic [31:0] r_out_ttl;

    logic        w_fire;
    logic        w_take;

    assign o_in_ready   = !r_out_valid || i_out_ready;
    assign w_fire       = i_in_valid && o_in_ready;
    assign w_take       = w_fire && !r_found && !r_failed;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_ip_address = r_ip;
    assign o_record_ttl = r_out_ttl;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_shift  = r_shift;
        n_qleft  = r_qleft;
        n_aleft  = r_aleft;
        n_lbl    = r_lbl;
        n_rtype  = r_rtype;
        n_rclass = r_rclass;
        n_ttl    = r_ttl;
        n_rdata  = r_rdata;
        n_found  = r_found;
        n_failed = r_failed;
        if (w_take) begin
            case (r_phase)
                PH_HDR: begin
                    if (r_count < HDR_ID_END) begin
                        n_shift = {r_shift[23:0], i_data_byte};
                    end else if (r_count < HDR_QD_END) begin
                        n_qleft = {r_qleft[7:0], i_data_byte};
                    end else if (r_count < HDR_AN_END) begin
                        n_aleft = {r_aleft[7:0], i_data_byte};
                    end
                    if (r_count == HDR_ID_END - 4'd1 &&
                        (n_shift[31:16] != r_expected_id ||
                         (n_shift[15:0] & QR_BIT) == 16'd0 ||
                         (n_shift[15:0] & RCODE_MASK) != 16'd0)) begin
                        n_failed = 1'b1;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_count = r_count + 4'd1;
                        if (r_count == HDR_LEN - 4'd1) begin
                            n_count = 4'd0;
                            n_shift = 32'd0;
                            if (n_qleft != 16'd0 || n_aleft != 16'd0) begin
                                n_phase = PH_NAME;
                            end else begin
                                n_failed = 1'b1;
                                n_phase  = PH_IDLE;
                            end
                        end
                    end
                end
                PH_NAME: begin
                    if (i_data_byte == 8'd0) begin
                        n_count = 4'd0;
                        n_phase = (r_qleft != 16'd0) ? PH_QFIX : PH_AFIX;
                    end else if ((i_data_byte & PTR_MARK) == PTR_MARK) begin
                        n_phase = PH_PTR;
                    end else if (i_data_byte > MAX_LABEL) begin
                        n_failed = 1'b1;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_lbl   = i_data_byte[5:0];
                        n_phase = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    n_lbl = r_lbl - 6'd1;
                    if (n_lbl == 6'd0) begin
                        n_phase = PH_NAME;
                    end
                end
                PH_PTR: begin
                    n_count = 4'd0;
                    n_phase = (r_qleft != 16'd0) ? PH_QFIX : PH_AFIX;
                end
                PH_QFIX: begin
                    n_count = r_count + 4'd1;
                    if (r_count == QFIX_LEN - 4'd1) begin
                        n_count = 4'd0;
                        n_qleft = r_qleft - 16'd1;
                        if (n_qleft != 16'd0 || r_aleft != 16'd0) begin
                            n_phase = PH_NAME;
                        end else begin
                            n_failed = 1'b1;
                            n_phase  = PH_IDLE;
                        end
                    end
                end
                PH_AFIX: begin
                    if (r_count < AF_TYPE_END) begin
                        n_rtype = {r_rtype[7:0], i_data_byte};
                    end else if (r_count < AF_CLASS_END) begin
                        n_rclass = {r_rclass[7:0], i_data_byte};
                    end else if (r_count < AF_TTL_END) begin
                        n_ttl = {r_ttl[23:0], i_data_byte};
                    end else begin
                        n_rdata = {r_rdata[7:0], i_data_byte};
                    end
                    n_count = r_count + 4'd1;
                    if (r_count == AFIX_LEN - 4'd1) begin
                        n_count = 4'd0;
                        if (n_rtype == TYPE_A && n_rclass == CLASS_IN &&
                            n_rdata == RDATA_A) begin
                            n_shift = 32'd0;
                            n_phase = PH_ADDR;
                        end else begin
                            n_rtype  = 16'd0;
                            n_rclass = 16'd0;
                            n_ttl    = 32'd0;
                            if (n_rdata == 16'd0) begin
                                n_aleft = r_aleft - 16'd1;
                                if (r_qleft != 16'd0 || n_aleft != 16'd0) begin
                                    n_phase = PH_NAME;
                                end else begin
                                    n_failed = 1'b1;
                                    n_phase  = PH_IDLE;
                                end
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP: begin
                    n_rdata = r_rdata - 16'd1;
                    if (n_rdata == 16'd0) begin
                        n_aleft = r_aleft - 16'd1;
                        if (r_qleft != 16'd0 || n_aleft != 16'd0) begin
                            n_phase = PH_NAME;
                        end else begin
                            n_failed = 1'b1;
                            n_phase  = PH_IDLE;
                        end
                    end
                end
                PH_ADDR: begin
                    n_shift = {r_shift[23:0], i_data_byte};
                    n_count = r_count + 4'd1;
                    if (r_count == ADDR_LEN - 4'd1) begin
                        n_found = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= 16'd0;
        end else if (i_cfg_wr_en) begin
            r_expected_id <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_fire && i_last_byte)) begin
            r_phase  <= PH_HDR;
            r_count  <= 4'd0;
            r_shift  <= 32'd0;
            r_qleft  <= 16'd0;
            r_aleft  <= 16'd0;
            r_lbl    <= 6'd0;
            r_rtype  <= 16'd0;
            r_rclass <= 16'd0;
            r_ttl    <= 32'd0;
            r_rdata  <= 16'd0;
            r_found  <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_shift  <= n_shift;
            r_qleft  <= n_qleft;
            r_aleft  <= n_aleft;
            r_lbl    <= n_lbl;
            r_rtype  <= n_rtype;
            r_rclass <= n_rclass;
            r_ttl    <= n_ttl;
            r_rdata  <= n_rdata;
            r_found  <= n_found;
            r_failed <= n_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status  <= 1'b0;
            r_ip      <= 32'd0;
            r_out_ttl <= 32'd0;
        end else if (w_fire && i_last_byte) begin
            r_status  <= !n_found;
            r_ip      <= n_found ? n_shift : 32'd0;
            r_out_ttl <= n_found ? n_ttl : 32'd0;
        end
    end

    a_fail_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> r_phase == PH_IDLE)
        else $error("failed message not parked");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_found && r_failed))
        else $error("found and failed both set");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_last_byte) |=> (o_out_valid && r_phase == PH_HDR &&
                                     !r_found && !r_failed && r_count == 4'd0))
        else $error("final byte did not clear parser");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_ip_address == 32'd0 && o_record_ttl == 32'd0))
        else $error("failure result carries data");

endmodule
